### rtl/csm_pkg.sv
package csm_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int COL_W = 10;
	localparam int ADDR_W = $clog2(MAX_COLUMNS);
	localparam int DATA_W = 32;
	localparam int ACC_W = 48;
	localparam int ROW_W = 16;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_ENTRY = 2'd1;
	localparam logic [1:0] ACT_EOR = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [COL_W-1:0] column;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} q_head_t;

endpackage

### rtl/csm_in_if.sv
interface csm_in_if
	import csm_pkg::*;
();
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [COL_W-1:0] column;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output action, output column, output value, input ready);
	modport sink (input valid, input action, input column, input value, output ready);
endinterface

### rtl/csm_out_if.sv
interface csm_out_if
	import csm_pkg::*;
();
	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] row_sum;
	logic [ROW_W-1:0] row_number;
	logic saturated;

	modport source (output valid, output row_sum, output row_number, output saturated,
		input ready);
	modport sink (input valid, input row_sum, input row_number, input saturated,
		output ready);
endinterface

### rtl/csm_ram.sv
module csm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/csm_front.sv
module csm_front
	import csm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	csm_in_if.sink items,
	input  logic pop,
	output q_head_t head
);
	item_t q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;
	logic accept;
	logic push;
	logic do_pop;

	assign items.ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign accept = items.valid && items.ready;
	// drop the unused action code
	assign push = accept && (items.action inside {ACT_WRITE, ACT_ENTRY, ACT_EOR});
	assign do_pop = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{action: items.action, column: items.column,
				value: items.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

### rtl/csm_back.sv
module csm_back
	import csm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  q_head_t head,
	output logic pop,
	csm_out_if.source results
);
	logic en;
	logic [DATA_W-1:0] rdata;
	logic wr_en;

	logic valid_s1;
	logic [1:0] action_s1;
	logic signed [DATA_W-1:0] value_s1;

	logic valid_s2;
	logic [1:0] action_s2;
	logic signed [2*DATA_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic [ROW_W-1:0] row_q;
	logic out_valid_q;
	logic signed [DATA_W-1:0] row_sum_q;
	logic [ROW_W-1:0] row_number_q;
	logic saturated_q;

	logic in_range;
	logic eor_s2;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W:0] sum;
	logic signed [ACC_W-1:0] acc_next;
	logic clip_hi;
	logic clip_lo;

	// hold the pipeline while a finished row waits on a full output register
	assign eor_s2 = valid_s2 && (action_s2 == ACT_EOR);
	assign en = !(eor_s2 && out_valid_q && !results.ready);
	assign pop = head.valid && en;
	assign in_range = (32'(head.item.column) < 32'(MAX_COLUMNS));
	assign wr_en = pop && (head.item.action == ACT_WRITE) && in_range;

	csm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLUMNS)) u_vec (
		.clk(clk),
		.we(wr_en),
		.waddr(ADDR_W'(head.item.column)),
		.wdata(head.item.value),
		.re(pop),
		.raddr(ADDR_W'(head.item.column)),
		.rdata(rdata)
	);

	logic zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1 <= head.item.action;
			value_s1 <= head.item.value;
			zero_s1 <= !in_range;
			action_s2 <= action_s1;
			prod_s2 <= zero_s1 ? $signed({(2*DATA_W){1'b0}}) : value_s1 * $signed(rdata);
		end
	end

	assign addend = prod_s2[2*DATA_W-1:16];
	assign sum = {acc_q[ACC_W-1], acc_q} + {addend[ACC_W-1], addend};
	always_comb begin
		acc_next = sum[ACC_W-1:0];
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	assign clip_hi = !acc_q[ACC_W-1] && (acc_q[ACC_W-2:DATA_W-1] != '0);
	assign clip_lo = acc_q[ACC_W-1] && (acc_q[ACC_W-2:DATA_W-1] != '1);

	always_ff @(posedge clk) begin
		if (en && eor_s2) begin
			row_number_q <= row_q;
			saturated_q <= clip_hi || clip_lo;
			if (clip_hi) begin
				row_sum_q <= {1'b0, {(DATA_W-1){1'b1}}};
			end else if (clip_lo) begin
				row_sum_q <= {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				row_sum_q <= acc_q[DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				valid_s1 <= pop && (head.item.action != ACT_WRITE);
				valid_s2 <= valid_s1;
				if (valid_s2 && action_s2 == ACT_ENTRY) begin
					acc_q <= acc_next;
				end
				if (eor_s2) begin
					acc_q <= '0;
					row_q <= row_q + 1'b1;
				end
			end
			out_valid_q <= (en && eor_s2) || (out_valid_q && !results.ready);
		end
	end

	assign results.valid = out_valid_q;
	assign results.row_sum = row_sum_q;
	assign results.row_number = row_number_q;
	assign results.saturated = saturated_q;
endmodule

### rtl/csr_sparse_matvec_top.sv
// Sparse matrix (CSR) times dense vector in Q16.16. Write the vector first
// (action 0), then stream nonzeros (action 1) and close each row (action 2),
// which returns the row sum saturated to 32 bits with its row number. One word
// is taken per clock while the front queue has room. With the queue empty, a
// nonzero passes the queue, the vector RAM read and the 32x32 multiply before
// the 48-bit add into the accumulator, and an end-of-row word passes the same
// registers before its row sum lands in the output register. The front queue
// holds four words, so input keeps being taken while the output stalls, until
// the queue fills. Vector entries never written read back as undefined.
module csr_sparse_matvec_top
	import csm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	csm_in_if.sink items,
	csm_out_if.source results
);
	q_head_t head;
	logic pop;

	csm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.pop(pop),
		.head(head)
	);

	csm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.results(results)
	);
endmodule

### tb/tb_csr_sparse_matvec_top.sv
`timescale 1ns / 100ps

module tb_csr_sparse_matvec_top;
	import csm_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int CLK_HALF = 4;
	localparam int RANDOM_WORDS = 525;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP = 40;
	localparam longint ACC_TOP = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_BOTTOM = -ACC_TOP - 1;
	localparam longint SUM_TOP = 64'sh0000_0000_7FFF_FFFF;
	localparam longint SUM_BOTTOM = -SUM_TOP - 1;

	typedef struct {
		logic signed [DATA_W-1:0] row_sum;
		logic [ROW_W-1:0] row_number;
		logic saturated;
	} row_result_t;

	logic clk;
	logic arst_n;

	csm_in_if items_if ();
	csm_out_if results_if ();

	csr_sparse_matvec_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	logic signed [DATA_W-1:0] vec_mem [MAX_COLUMNS];
	bit vec_written [MAX_COLUMNS];
	int vec_cols [$];
	logic signed [ACC_W-1:0] row_acc;
	logic [ROW_W-1:0] row_idx;
	row_result_t pending_rows [$];
	row_result_t head_row;

	bit no_gaps;
	int out_hold;
	int errors;
	int words_sent;
	int rows_checked;
	int rows_clipped;
	int cycle_count;

	always #CLK_HALF clk = ~clk;

	task automatic report_error(input string msg);
		if (errors < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void accumulate_word(input logic [1:0] act,
			input logic [COL_W-1:0] col, input logic signed [DATA_W-1:0] val);
		longint prod;
		longint total;
		row_result_t row;
		case (act)
			ACT_WRITE: begin
				vec_mem[col] = val;
				if (!vec_written[col]) begin
					vec_written[col] = 1'b1;
					vec_cols.push_back(int'(col));
				end
			end
			ACT_ENTRY: begin
				prod = longint'(val) * longint'(vec_mem[col]);
				total = longint'(row_acc) + (prod >>> 16);
				if (total > ACC_TOP)
					total = ACC_TOP;
				else if (total < ACC_BOTTOM)
					total = ACC_BOTTOM;
				row_acc = total[ACC_W-1:0];
			end
			ACT_EOR: begin
				total = longint'(row_acc);
				row.saturated = 1'b0;
				if (total > SUM_TOP) begin
					total = SUM_TOP;
					row.saturated = 1'b1;
				end else if (total < SUM_BOTTOM) begin
					total = SUM_BOTTOM;
					row.saturated = 1'b1;
				end
				row.row_sum = total[DATA_W-1:0];
				row.row_number = row_idx;
				pending_rows.push_back(row);
				row_acc = '0;
				row_idx = row_idx + 1'b1;
			end
			default: ;
		endcase
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic [1:0] act, input logic [COL_W-1:0] col,
			input logic [DATA_W-1:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.action <= act;
		items_if.column <= col;
		items_if.value <= val;
		do
			@(posedge clk);
		while (!items_if.ready);
		accumulate_word(act, col, val);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
	endfunction

	function automatic logic [COL_W-1:0] pick_written_col();
		return COL_W'(vec_cols[$urandom_range(0, vec_cols.size() - 1)]);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d rows pending", cycle_count,
				pending_rows.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_rows.size() == 0) begin
				report_error($sformatf("row %0d arrived with none expected",
					results_if.row_number));
			end else begin
				head_row = pending_rows.pop_front();
				if (results_if.row_sum !== head_row.row_sum)
					report_error($sformatf("row %0d row_sum %h, expected %h",
						head_row.row_number, results_if.row_sum, head_row.row_sum));
				if (results_if.row_number !== head_row.row_number)
					report_error($sformatf("row_number %h, expected %h",
						results_if.row_number, head_row.row_number));
				if (results_if.saturated !== head_row.saturated)
					report_error($sformatf("row %0d saturated %b, expected %b",
						head_row.row_number, results_if.saturated, head_row.saturated));
				if (head_row.saturated)
					rows_clipped++;
			end
			rows_checked++;
			out_hold = no_gaps ? 0 : $urandom_range(0, 15);
		end
	end

	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_hold > 0) begin
				results_if.ready <= 1'b0;
				out_hold--;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	task automatic test_vector_load();
		send_word(ACT_WRITE, 10'd0, 32'h7FFF_FFFF);
		send_word(ACT_WRITE, 10'd1023, 32'h8000_0000);
		send_word(ACT_WRITE, 10'h155, 32'hFFFF_FFFF);
		send_word(ACT_WRITE, 10'h2AA, 32'h0001_0000);
		send_word(ACT_WRITE, 10'd5, 32'h0000_0000);
	endtask

	task automatic test_empty_row();
		send_word(ACT_EOR, 10'd0, 32'h0);
	endtask

	// products with dropped fraction bits round toward minus infinity
	task automatic test_floor_rounding();
		send_word(ACT_ENTRY, 10'h155, 32'h0000_0001);
		send_word(ACT_ENTRY, 10'h155, 32'h0000_0003);
		send_word(ACT_ENTRY, 10'd5, 32'h1234_5678);
		send_word(ACT_EOR, 10'h3FF, 32'hFFFF_FFFF);
	endtask

	task automatic test_acc_saturation();
		repeat (3) send_word(ACT_ENTRY, 10'd1023, 32'h8000_0000);
		send_word(ACT_EOR, 10'd0, 32'h0);
		repeat (3) send_word(ACT_ENTRY, 10'd1023, 32'h7FFF_FFFF);
		send_word(ACT_EOR, 10'd0, 32'h0);
	endtask

	task automatic test_sum_boundary();
		send_word(ACT_ENTRY, 10'h2AA, 32'h7FFF_FFFF);
		send_word(ACT_EOR, 10'd0, 32'h0);
		send_word(ACT_ENTRY, 10'h2AA, 32'h7FFF_FFFF);
		send_word(ACT_ENTRY, 10'h2AA, 32'h0000_0001);
		send_word(ACT_EOR, 10'd0, 32'h0);
		send_word(ACT_ENTRY, 10'h2AA, 32'h8000_0000);
		send_word(ACT_ENTRY, 10'h2AA, 32'hFFFF_FFFF);
		send_word(ACT_EOR, 10'd0, 32'h0);
	endtask

	task automatic test_spare_action();
		send_word(ACT_ENTRY, 10'd0, 32'h0002_0000);
		send_word(ACT_SPARE, 10'h3FF, 32'hFFFF_FFFF);
		send_word(ACT_SPARE, 10'd0, 32'h0);
		send_word(ACT_EOR, 10'd0, 32'h0);
	endtask

	task automatic test_random_rows();
		int sent;
		int roll;
		logic [COL_W-1:0] col;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if (sent % 50 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				col = COL_W'($urandom_range(0, MAX_COLUMNS - 1));
				send_word(ACT_WRITE, col, pick_value());
				sent++;
			end else if (roll < 78) begin
				send_word(ACT_ENTRY, pick_written_col(), pick_value());
				sent++;
			end else if (roll < 97) begin
				send_word(ACT_EOR, COL_W'($urandom), $urandom);
				sent++;
			end else begin
				send_word(ACT_SPARE, COL_W'($urandom), $urandom);
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic finish_run();
		items_if.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rows.size() != 0 || errors != 0)
			$display("%0d mismatches", errors);
		$display("Sent %0d words; checked %0d row sums, %0d of them clipped to 32 bits.",
			words_sent, rows_checked, rows_clipped);
		$display("Directed extremes, floor rounding, both saturations, spare action code.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.action = ACT_WRITE;
		items_if.column = '0;
		items_if.value = '0;
		row_acc = '0;
		row_idx = '0;
		no_gaps = 1'b0;
		out_hold = 0;
		errors = 0;
		words_sent = 0;
		rows_checked = 0;
		rows_clipped = 0;
		cycle_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_vector_load();
		test_empty_row();
		test_floor_rounding();
		test_acc_saturation();
		test_sum_boundary();
		test_spare_action();
		test_random_rows();
		finish_run();
	end

endmodule

### filelist.f
rtl/csm_pkg.sv
rtl/csm_in_if.sv
rtl/csm_out_if.sv
rtl/csm_ram.sv
rtl/csm_front.sv
rtl/csm_back.sv
rtl/csr_sparse_matvec_top.sv
tb/tb_csr_sparse_matvec_top.sv
